>>> src/spi_pkg.sv
// shared types and constants for the segment pair intersection block
package spi_pkg;

	localparam int FIELD_BITS = 16;
	localparam int OUT_BITS   = 32;
	localparam int DEF_COORD_BITS = 16;
	localparam int DEF_FRAC_BITS  = 16;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] seg_a_start_x;
		logic signed [FIELD_BITS-1:0] seg_a_start_y;
		logic signed [FIELD_BITS-1:0] seg_a_end_x;
		logic signed [FIELD_BITS-1:0] seg_a_end_y;
		logic signed [FIELD_BITS-1:0] seg_b_start_x;
		logic signed [FIELD_BITS-1:0] seg_b_start_y;
		logic signed [FIELD_BITS-1:0] seg_b_end_x;
		logic signed [FIELD_BITS-1:0] seg_b_end_y;
	} seg_pair_t;

	typedef struct packed {
		logic                       hit;
		logic                       parallel;
		logic signed [OUT_BITS-1:0] cross_x;
		logic signed [OUT_BITS-1:0] cross_y;
	} cross_t;

endpackage

>>> src/segment_pair_intersection.sv
// segment pair intersection: top level
//
// input channel in_valid/in_ready/in_data carries one segment pair per
// transaction; output channel out_valid/out_ready/out_data returns one
// result per pair, in order.
// the result holds hit, parallel and the crossing point in signed fixed
// point with FRAC_BITS fraction bits (zero when there is no hit).
// the divider quotient holds W + FRAC_BITS bits, with W = min(COORD_BITS, 16);
// the pipeline length is set by the restoring divider, which retires one
// quotient bit per stage.
// throughput is one pair per cycle while no waiting result is held back by out_ready.
// when the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops in the same cycle; nothing is lost
// or repeated.
// reset clears all valid bits; the pipeline is then empty and ready.
module segment_pair_intersection import spi_pkg::*; #(
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  seg_pair_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output cross_t    out_data
);

	localparam int W    = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
	localparam int DW   = W + 1;
	localparam int PW   = 2 * W + 2;
	localparam int NB   = 2 * W + 3;
	localparam int MB   = NB - 1;
	localparam int HALF = (MB + 1) / 2;
	localparam int XB   = DW + MB;
	localparam int XP   = XB + FRAC_BITS;
	localparam int QB   = W + FRAC_BITS;
	localparam int EW   = (W + FRAC_BITS + 3 > OUT_BITS + 1) ? W + FRAC_BITS + 3 : OUT_BITS + 1;

	typedef struct packed {
		logic                valid;
		logic                hit;
		logic                parallel;
		logic                neg_x;
		logic                neg_y;
		logic signed [W-1:0] base_x;
		logic signed [W-1:0] base_y;
	} side_t;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: coordinate differences
	logic                 v_s1;
	logic signed [DW-1:0] p_s1, q_s1, u_s1, s_s1, w_s1, vv_s1;
	logic signed [W-1:0]  bx_s1, by_s1;
	logic signed [W-1:0]  a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;

	always_comb begin
		a1x = in_data.seg_a_start_x[W-1:0];
		a1y = in_data.seg_a_start_y[W-1:0];
		a2x = in_data.seg_a_end_x[W-1:0];
		a2y = in_data.seg_a_end_y[W-1:0];
		b1x = in_data.seg_b_start_x[W-1:0];
		b1y = in_data.seg_b_start_y[W-1:0];
		b2x = in_data.seg_b_end_x[W-1:0];
		b2y = in_data.seg_b_end_y[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= DW'(a2x) - DW'(a1x);
			q_s1  <= DW'(b1x) - DW'(b2x);
			u_s1  <= DW'(b1x) - DW'(a1x);
			s_s1  <= DW'(a2y) - DW'(a1y);
			w_s1  <= DW'(b1y) - DW'(b2y);
			vv_s1 <= DW'(b1y) - DW'(a1y);
			bx_s1 <= a1x;
			by_s1 <= a1y;
		end
	end

	// stage 2: cramer determinants
	logic signed [PW-1:0] m_pw, m_sq, m_uw, m_vq, m_pv, m_su;
	logic                 v_s2;
	logic signed [NB-1:0] det_s2, rnum_s2, tnum_s2;
	logic signed [DW-1:0] p_s2, s_s2;
	logic signed [W-1:0]  bx_s2, by_s2;

	always_comb begin
		m_pw = p_s1 * w_s1;
		m_sq = s_s1 * q_s1;
		m_uw = u_s1 * w_s1;
		m_vq = vv_s1 * q_s1;
		m_pv = p_s1 * vv_s1;
		m_su = s_s1 * u_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s2  <= NB'(m_pw) - NB'(m_sq);
			rnum_s2 <= NB'(m_uw) - NB'(m_vq);
			tnum_s2 <= NB'(m_pv) - NB'(m_su);
			p_s2    <= p_s1;
			s_s2    <= s_s1;
			bx_s2   <= bx_s1;
			by_s2   <= by_s1;
		end
	end

	// stage 3: range tests and magnitudes
	logic          r_in, t_in, det_zero;
	logic          v_s3;
	side_t         sb_s3;
	logic [DW-1:0] pm_s3, sm_s3;
	logic [MB-1:0] rm_s3, dm_s3;
	logic [NB-1:0] rabs, dabs;
	logic [DW-1:0] pabs, sabs;

	always_comb begin
		det_zero = det_s2 == '0;
		if (det_s2 > 0) begin
			r_in = rnum_s2 > 0 && rnum_s2 < det_s2;
			t_in = tnum_s2 > 0 && tnum_s2 < det_s2;
		end else begin
			r_in = rnum_s2 < 0 && rnum_s2 > det_s2;
			t_in = tnum_s2 < 0 && tnum_s2 > det_s2;
		end
		rabs = rnum_s2[NB-1] ? -rnum_s2 : rnum_s2;
		dabs = det_s2[NB-1] ? -det_s2 : det_s2;
		pabs = p_s2[DW-1] ? -p_s2 : p_s2;
		sabs = s_s2[DW-1] ? -s_s2 : s_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s3.valid    <= v_s2;
			sb_s3.parallel <= det_zero;
			sb_s3.hit      <= !det_zero && r_in && t_in;
			sb_s3.neg_x    <= p_s2[DW-1] ^ rnum_s2[NB-1] ^ det_s2[NB-1];
			sb_s3.neg_y    <= s_s2[DW-1] ^ rnum_s2[NB-1] ^ det_s2[NB-1];
			sb_s3.base_x   <= bx_s2;
			sb_s3.base_y   <= by_s2;
			pm_s3          <= pabs;
			sm_s3          <= sabs;
			rm_s3          <= rabs[MB-1:0];
			dm_s3          <= dabs[MB-1:0];
		end
	end

	// stage 4: partial products of the dividend
	logic                       v_s4;
	side_t                      sb_s4;
	logic [DW+HALF-1:0]         xl_s4, yl_s4;
	logic [DW+MB-HALF-1:0]      xh_s4, yh_s4;
	logic [MB-1:0]              dm_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s4 <= sb_s3;
			xl_s4 <= pm_s3 * rm_s3[HALF-1:0];
			xh_s4 <= pm_s3 * rm_s3[MB-1:HALF];
			yl_s4 <= sm_s3 * rm_s3[HALF-1:0];
			yh_s4 <= sm_s3 * rm_s3[MB-1:HALF];
			dm_s4 <= dm_s3;
		end
	end

	// stage 5: full dividends
	logic          v_s5;
	side_t         sb_s5;
	logic [XB-1:0] xn_s5, yn_s5;
	logic [MB-1:0] dm_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s5 <= sb_s4;
			xn_s5 <= (XB'(xh_s4) << HALF) + XB'(xl_s4);
			yn_s5 <= (XB'(yh_s4) << HALF) + XB'(yl_s4);
			dm_s5 <= dm_s4;
		end
	end

	// dividers and the matching sideband line
	logic [QB-1:0] quo_x, quo_y;
	side_t         side_q [0:QB];
	logic          sv_q   [0:QB];

	spi_div #(.MB(MB), .QB(QB), .XP(XP)) u_div_x (
		.clk      (clk),
		.en       (en),
		.dividend (XP'(xn_s5) << FRAC_BITS),
		.divisor  (dm_s5),
		.quotient (quo_x)
	);

	spi_div #(.MB(MB), .QB(QB), .XP(XP)) u_div_y (
		.clk      (clk),
		.en       (en),
		.dividend (XP'(yn_s5) << FRAC_BITS),
		.divisor  (dm_s5),
		.quotient (quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q[0] <= 1'b0;
		end else if (en) begin
			sv_q[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= sb_s5;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_q[k] <= 1'b0;
			end else if (en) begin
				sv_q[k] <= sv_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// final stage: add base, saturate, mask
	side_t                sb_f;
	logic signed [EW-1:0] bx_e, by_e, qx_e, qy_e, sx_e, sy_e;
	logic signed [OUT_BITS-1:0] cx, cy;
	localparam logic signed [EW-1:0] SAT_HI = EW'(33'sh0_7fff_ffff);
	localparam logic signed [EW-1:0] SAT_LO = EW'(33'sh1_8000_0000);

	always_comb begin
		sb_f = side_q[QB];
		bx_e = EW'(sb_f.base_x) <<< FRAC_BITS;
		by_e = EW'(sb_f.base_y) <<< FRAC_BITS;
		qx_e = $signed(EW'(quo_x));
		qy_e = $signed(EW'(quo_y));
		sx_e = sb_f.neg_x ? bx_e - qx_e : bx_e + qx_e;
		sy_e = sb_f.neg_y ? by_e - qy_e : by_e + qy_e;
		priority if (sx_e > SAT_HI) begin
			cx = OUT_BITS'(SAT_HI);
		end else if (sx_e < SAT_LO) begin
			cx = OUT_BITS'(SAT_LO);
		end else begin
			cx = OUT_BITS'(sx_e);
		end
		priority if (sy_e > SAT_HI) begin
			cy = OUT_BITS'(SAT_HI);
		end else if (sy_e < SAT_LO) begin
			cy = OUT_BITS'(SAT_LO);
		end else begin
			cy = OUT_BITS'(sy_e);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= sv_q[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.hit      <= sb_f.hit;
			out_data.parallel <= sb_f.parallel;
			out_data.cross_x  <= sb_f.hit ? cx : '0;
			out_data.cross_y  <= sb_f.hit ? cy : '0;
		end
	end

	// a result never claims both a crossing and a zero determinant
	a_hit_not_parallel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.hit && out_data.parallel))
		else $error("hit and parallel both set");

	// no crossing means a zero point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.hit) |-> (out_data.cross_x == '0 && out_data.cross_y == '0))
		else $error("point nonzero without hit");

	// a stalled pipeline freezes the sideband entering the output stage
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sv_q[QB]) && $stable(side_q[QB]))
		else $error("pipeline moved during stall");

	// the sideband valid line matches the stage valid it was loaded from
	a_side_valid: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q[0] |-> side_q[0].valid)
		else $error("sideband valid mismatch");

endmodule

>>> src/spi_div.sv
// pipelined restoring divider, one quotient bit per stage
module spi_div import spi_pkg::*; #(
	parameter int MB = 34,
	parameter int QB = 32,
	parameter int XP = 67
) (
	input  logic          clk,
	input  logic          en,
	input  logic [XP-1:0] dividend,
	input  logic [MB-1:0] divisor,
	output logic [QB-1:0] quotient
);

	localparam int RB = XP - QB;

	logic [RB-1:0] rem_q [0:QB];
	logic [QB-1:0] low_q [0:QB];
	logic [QB-1:0] quo_q [0:QB];
	logic [MB-1:0] den_q [0:QB];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= dividend[XP-1:QB];
			low_q[0] <= dividend[QB-1:0];
			quo_q[0] <= '0;
			den_q[0] <= divisor;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		logic [MB:0] trial;
		logic [MB:0] diff;
		logic        take;

		always_comb begin
			trial = {rem_q[k-1][MB-1:0], low_q[k-1][QB-1]};
			diff  = trial - {1'b0, den_q[k-1]};
			take  = trial >= {1'b0, den_q[k-1]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= take ? RB'(diff) : RB'(trial);
				low_q[k] <= {low_q[k-1][QB-2:0], 1'b0};
				quo_q[k] <= {quo_q[k-1][QB-2:0], take};
				den_q[k] <= den_q[k-1];
			end
		end
	end

	assign quotient = quo_q[QB];

endmodule

>>> verif/segment_pair_intersection_test.sv
// testbench for the segment pair intersection block
`timescale 1ns / 100ps

module segment_pair_intersection_test;
	import spi_pkg::*;

	localparam int LATENCY = 39;

	class crossing_board;
		cross_t pending[$];
		int mismatches;
		int fails;

		// expected crossing for one segment pair, exact integer arithmetic
		function cross_t predict(seg_pair_t sp);
			cross_t r;
			longint p, q, u, s, w, v, det, rn, tn, px, py;
			bit rin, tin;
			p = longint'(sp.seg_a_end_x) - longint'(sp.seg_a_start_x);
			q = -(longint'(sp.seg_b_end_x) - longint'(sp.seg_b_start_x));
			u = longint'(sp.seg_b_start_x) - longint'(sp.seg_a_start_x);
			s = longint'(sp.seg_a_end_y) - longint'(sp.seg_a_start_y);
			w = -(longint'(sp.seg_b_end_y) - longint'(sp.seg_b_start_y));
			v = longint'(sp.seg_b_start_y) - longint'(sp.seg_a_start_y);
			det = p * w - s * q;
			rn = u * w - v * q;
			tn = p * v - s * u;
			r = '0;
			if (det == 0) begin
				r.parallel = 1'b1;
				return r;
			end
			rin = det > 0 ? (rn > 0 && rn < det) : (rn < 0 && rn > det);
			tin = det > 0 ? (tn > 0 && tn < det) : (tn < 0 && tn > det);
			if (!(rin && tin))
				return r;
			r.hit = 1'b1;
			px = along(longint'(sp.seg_a_start_x), p, rn, det);
			py = along(longint'(sp.seg_a_start_y), s, rn, det);
			r.cross_x = px[31:0];
			r.cross_y = py[31:0];
			return r;
		endfunction

		function longint along(longint base, longint d, longint num, longint den);
			longint n, qi, rem;
			n = d * num;
			qi = n / den;
			rem = n - qi * den;
			return base * 65536 + qi * 65536 + (rem * 65536) / den;
		endfunction

		function void note_pair(seg_pair_t sp);
			pending.push_back(predict(sp));
		endfunction

		function void check_result(cross_t got);
			cross_t exp_r;
			if (pending.size() == 0) begin
				fails++;
				if (mismatches++ < 10)
					$display("unexpected result %p", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				fails++;
				if (mismatches++ < 10)
					$display("mismatch: expected %p got %p", exp_r, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	seg_pair_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	cross_t out_data;

	crossing_board board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;

	always #2 clk = ~clk;

	segment_pair_intersection u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// receiver side and checking
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(out_data);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($signed($urandom_range(40)) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	// valid stays high after acceptance so the next transaction can follow directly
	task automatic send_pair(seg_pair_t sp);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= sp;
		do @(posedge clk); while (!in_ready);
		board.note_pair(sp);
	endtask

	// segment pairs laid across a common centre point, so hits are frequent
	function automatic seg_pair_t crossing_pair(int span);
		seg_pair_t sp;
		int cx, cy;
		cx = $urandom_range(2 * span) - span;
		cy = $urandom_range(2 * span) - span;
		sp.seg_a_start_x = 16'(cx - int'($urandom_range(span)) - 1);
		sp.seg_a_start_y = 16'(cy - int'($urandom_range(span)) - 1);
		sp.seg_a_end_x = 16'(cx + int'($urandom_range(span)) + 1);
		sp.seg_a_end_y = 16'(cy + int'($urandom_range(span)) + 1);
		sp.seg_b_start_x = 16'(cx - int'($urandom_range(span)) - 1);
		sp.seg_b_start_y = 16'(cy + int'($urandom_range(span)) + 1);
		sp.seg_b_end_x = 16'(cx + int'($urandom_range(span)) + 1);
		sp.seg_b_end_y = 16'(cy - int'($urandom_range(span)) - 1);
		return sp;
	endfunction

	task automatic drain();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (board.pending.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	initial begin
		seg_pair_t sp;
		int idle_pct[4];
		int stall_pct[4];
		idle_pct = '{0, 87, 0, 8};
		stall_pct = '{0, 0, 87, 8};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// crossing, parallel, collinear overlap, endpoint touch, extremes
		send_pair('{0, 0, 10, 10, 0, 10, 10, 0});
		send_pair('{0, 0, 10, 0, 0, 5, 10, 5});
		send_pair('{0, 0, 10, 0, 5, 0, 15, 0});
		send_pair('{0, 0, 10, 10, 10, 10, 20, 0});
		send_pair('{0, 0, 10, 0, 5, 0, 5, 10});
		send_pair('{0, 0, 3, 0, 1, -1, 2, 1});
		send_pair('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768});
		send_pair('{32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767});
		send_pair('{-32768, 0, 32767, 1, 0, -32768, 1, 32767});
		send_pair('{0, 0, 0, 0, 0, 0, 0, 0});
		send_pair('{1, 1, 1, 1, -1, -1, 2, 2});
		send_pair('{0, 0, 7, 3, 0, 3, 7, 0});
		send_pair('{-5, 2, 9, -7, 3, -8, -1, 6});
		send_pair('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff});
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_pct[ph];
			recv_stall_pct = stall_pct[ph];
			for (int i = 0; i < 380; i++) begin
				if ($urandom_range(99) < 60)
					sp = crossing_pair($urandom_range(1) ? 30 : 16000);
				else
					for (int k = 0; k < 8; k++) sp[k*16 +: 16] = rand_coord();
				send_pair(sp);
				if (ph == 0 && i == 100)
					hold_off = 300;
			end
			// sender pauses until everything has come back
			drain();
		end

		if (board.fails == 0 && board.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
